/* hdl/alu8bm_pkg.sv */
// ----------------------------------------------------------------------------
// alu8bm_pkg
// Opcodes, pipeline word types and the Booth step function for the ALU.
// ----------------------------------------------------------------------------
package alu8bm_pkg;

  // opcodes
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_MUL = 4'd3;
  localparam logic [3:0] OP_AND = 4'd4;
  localparam logic [3:0] OP_OR  = 4'd5;
  localparam logic [3:0] OP_NOT = 4'd6;
  localparam logic [3:0] OP_XOR = 4'd7;
  localparam logic [3:0] OP_SHR = 4'd8;
  localparam logic [3:0] OP_SHL = 4'd9;

  // flag thresholds
  localparam logic [15:0] CARRY_LIMIT = 16'h01FF;
  localparam logic [15:0] OVF_LIMIT   = 16'h00FF;

  // Booth iteration split over the pipeline
  localparam int BOOTH_STEPS     = 8;
  localparam int STEPS_PER_STAGE = 2;
  localparam int BOOTH_STAGES    = BOOTH_STEPS / STEPS_PER_STAGE;

  // word carried down the pipeline
  typedef struct packed {
    logic        is_mul;
    logic [15:0] alt_result;  // result of every non-multiply opcode
    logic [7:0]  m;           // multiplicand
    logic [7:0]  acc;         // Booth A register
    logic [7:0]  q;           // Booth Q register
    logic        qn1;         // Booth Q(-1)
  } pipe_word_t;

  // one radix-2 Booth step; A wraps at 8 bits
  function automatic pipe_word_t booth_step(input pipe_word_t w);
    pipe_word_t o;
    logic [7:0] sum;
    o = w;
    case ({w.q[0], w.qn1})
      2'b10:   sum = w.acc - w.m;
      2'b01:   sum = w.acc + w.m;
      default: sum = w.acc;
    endcase
    o.qn1 = w.q[0];
    o.q   = {sum[0], w.q[7:1]};
    o.acc = {sum[7], sum[7:1]};
    return o;
  endfunction

endpackage

/* hdl/alu8bm_logic_unit.sv */
// ----------------------------------------------------------------------------
// alu8bm_logic_unit
// Add, subtract, bitwise and shift results; unknown opcodes give zero.
// ----------------------------------------------------------------------------
module alu8bm_logic_unit
  import alu8bm_pkg::*;
(
  input  logic [7:0]  operand_a,
  input  logic [7:0]  operand_b,
  input  logic [3:0]  opcode,
  output logic [15:0] result
);

  logic [7:0]  neg_b;
  logic [15:0] shl_val;

  assign neg_b   = ~operand_b + 8'd1;
  assign shl_val = {8'd0, operand_a} << operand_b[3:0];

  always_comb begin
    case (opcode)
      OP_ADD: result = {7'd0, {1'b0, operand_a} + {1'b0, operand_b}};
      OP_SUB: result = {7'd0, {1'b0, operand_a} + {1'b0, neg_b}};
      OP_AND: result = {8'd0, operand_a & operand_b};
      OP_OR:  result = {8'd0, operand_a | operand_b};
      OP_NOT: result = {8'd0, ~operand_a};
      OP_XOR: result = {8'd0, operand_a ^ operand_b};
      // shift by 8 or more clears everything
      OP_SHR: result = (operand_b < 8'd8) ? {8'd0, operand_a >> operand_b[2:0]} : 16'd0;
      // shift by 16 or more clears everything
      OP_SHL: result = (operand_b < 8'd16) ? shl_val : 16'd0;
      default: result = 16'd0;
    endcase
  end

endmodule

/* hdl/alu8bm_booth_stage.sv */
// ----------------------------------------------------------------------------
// alu8bm_booth_stage
// One pipeline stage running STEPS_PER_STAGE Booth steps on the word.
// ----------------------------------------------------------------------------
module alu8bm_booth_stage
  import alu8bm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       vld_i,
  input  pipe_word_t word_i,
  output logic       rdy_o,
  output logic       vld_o,
  output pipe_word_t word_o,
  input  logic       rdy_i
);

  logic       vld_r;
  pipe_word_t word_r;
  pipe_word_t word_nxt;

  // Booth steps for this stage
  always_comb begin
    word_nxt = word_i;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      word_nxt = booth_step(word_nxt);
    end
  end

  // stage moves when empty or downstream takes its word
  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      word_r <= word_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign word_o = word_r;

endmodule

/* hdl/alu8_with_booth_multiply.sv */
// ----------------------------------------------------------------------------
// alu8_with_booth_multiply: each accepted word passes the entry, Booth and flag stages in turn.
// Throughput one word per cycle while out_stall is low; entry stage, four Booth stages, flag stage.
// Synchronous active-low reset empties every stage; no words are held over.
// ----------------------------------------------------------------------------
module alu8_with_booth_multiply
  import alu8bm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_operand_a,
  input  logic [7:0]  in_operand_b,
  input  logic [3:0]  in_opcode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_result,
  output logic        out_zero_flag,
  output logic        out_carry_flag,
  output logic        out_sign_flag,
  output logic        out_overflow_flag
);

  logic [15:0] alt_res;
  logic        ent_vld_r;
  pipe_word_t  ent_word_r;
  pipe_word_t  ent_word_nxt;
  logic        ent_rdy;

  logic       stg_vld [BOOTH_STAGES+1];
  pipe_word_t stg_word[BOOTH_STAGES+1];
  logic       stg_rdy [BOOTH_STAGES+1];

  logic        out_valid_r;
  logic [15:0] res_r;
  logic        zf_r, cf_r, sf_r, of_r;
  logic        out_rdy;
  logic [15:0] res_nxt;

  // non-multiply results
  alu8bm_logic_unit u_logic (
    .operand_a(in_operand_a),
    .operand_b(in_operand_b),
    .opcode   (in_opcode),
    .result   (alt_res)
  );

  // entry word: Booth A and Q(-1) start cleared, Q holds operand_b
  always_comb begin
    ent_word_nxt.is_mul     = (in_opcode == OP_MUL);
    ent_word_nxt.alt_result = alt_res;
    ent_word_nxt.m          = in_operand_a;
    ent_word_nxt.acc        = 8'd0;
    ent_word_nxt.q          = in_operand_b;
    ent_word_nxt.qn1        = 1'b0;
  end

  assign ent_rdy  = !ent_vld_r || stg_rdy[0];
  assign in_stall = !ent_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
    end else if (ent_rdy) begin
      ent_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_rdy && in_valid) begin
      ent_word_r <= ent_word_nxt;
    end
  end

  assign stg_vld[0]  = ent_vld_r;
  assign stg_word[0] = ent_word_r;

  // Booth stages
  for (genvar s = 0; s < BOOTH_STAGES; s++) begin : g_booth
    alu8bm_booth_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (stg_vld[s]),
      .word_i(stg_word[s]),
      .rdy_o (stg_rdy[s]),
      .vld_o (stg_vld[s+1]),
      .word_o(stg_word[s+1]),
      .rdy_i (stg_rdy[s+1])
    );
  end

  // output stage: result select and flags
  assign out_rdy              = !out_valid_r || !out_stall;
  assign stg_rdy[BOOTH_STAGES] = out_rdy;

  assign res_nxt = stg_word[BOOTH_STAGES].is_mul
                 ? {stg_word[BOOTH_STAGES].acc, stg_word[BOOTH_STAGES].q}
                 : stg_word[BOOTH_STAGES].alt_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= stg_vld[BOOTH_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && stg_vld[BOOTH_STAGES]) begin
      res_r <= res_nxt;
      zf_r  <= (res_nxt == 16'd0);
      cf_r  <= (res_nxt >= CARRY_LIMIT);
      sf_r  <= res_nxt[7];
      of_r  <= (res_nxt >= OVF_LIMIT);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result        = res_r;
  assign out_zero_flag     = zf_r;
  assign out_carry_flag    = cf_r;
  assign out_sign_flag     = sf_r;
  assign out_overflow_flag = of_r;

endmodule
